[rtl/ellipse_pixel_shader_core_macros.svh]
// Assertion macros for the ellipse pixel shader core
`ifndef ELLIPSE_PIXEL_SHADER_CORE_MACROS_SVH
`define ELLIPSE_PIXEL_SHADER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define EPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

`define EPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define EPS_ASSERT_IMPL(lbl, ante, cons)

`define EPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/eps_pkg.sv]
// Shared types and constants for the ellipse pixel shader core
package eps_pkg;

  localparam int FOCUS_W    = 16;
  localparam int LIMIT_W    = 19;
  localparam int COLOR_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCUS_ONE_X = 3'd0,
    REG_FOCUS_ONE_Y = 3'd1,
    REG_FOCUS_TWO_X = 3'd2,
    REG_FOCUS_TWO_Y = 3'd3,
    REG_LENGTH_LIMIT = 3'd4,
    REG_FILL_RED    = 3'd5,
    REG_FILL_GREEN  = 3'd6,
    REG_FILL_BLUE   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic   valid;
    color_t color;
  } cell_ctl_t;

endpackage

[rtl/ellipse_pixel_shader_core.sv]
// Top level of the ellipse pixel shader core: distance lanes, root chain, compare
//
//  channel   handshake            payload
//  --------  -------------------  -----------------------------------------
//  pixel in  start / busy         pixel_x, pixel_y, old_red/green/blue
//  result    done (strobe)        new_red/green/blue, inside_res
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel enters every cycle; busy stays low.
// done follows the capture, difference, square, radicand, root chain (ROOT_W cells,
// one result bit per cell; 18 by default), sum and compare registers.
// Reset clears the pipeline valid bits and all configuration registers.
// The receiver cannot stall: each result shows for one cycle with done high.
module ellipse_pixel_shader_core import eps_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [COLOR_W-1:0]    old_red,
  input  logic [COLOR_W-1:0]    old_green,
  input  logic [COLOR_W-1:0]    old_blue,
  output logic                  done,
  output logic [COLOR_W-1:0]    new_red,
  output logic [COLOR_W-1:0]    new_green,
  output logic [COLOR_W-1:0]    new_blue,
  output logic                  inside_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "ellipse_pixel_shader_core_macros.svh"

  localparam int PX_W   = COORD_BITS + FRAC_BITS;
  localparam int D_W    = ((PX_W + 1 > FOCUS_W) ? PX_W + 1 : FOCUS_W) + 1;
  localparam int ROOT_W = D_W;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SUM_W  = ROOT_W + 2;
  localparam int CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
  localparam int LANES  = 3;

  // configuration registers
  logic signed [FOCUS_W-1:0] focus_one_x, focus_one_y, focus_two_x, focus_two_y;
  logic [LIMIT_W-1:0]        length_limit;
  color_t                    fill;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      focus_one_x  <= '0;
      focus_one_y  <= '0;
      focus_two_x  <= '0;
      focus_two_y  <= '0;
      length_limit <= '0;
      fill         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FOCUS_ONE_X:  focus_one_x  <= cfg_data[FOCUS_W-1:0];
        REG_FOCUS_ONE_Y:  focus_one_y  <= cfg_data[FOCUS_W-1:0];
        REG_FOCUS_TWO_X:  focus_two_x  <= cfg_data[FOCUS_W-1:0];
        REG_FOCUS_TWO_Y:  focus_two_y  <= cfg_data[FOCUS_W-1:0];
        REG_LENGTH_LIMIT: length_limit <= cfg_data[LIMIT_W-1:0];
        REG_FILL_RED:     fill.red     <= cfg_data[COLOR_W-1:0];
        REG_FILL_GREEN:   fill.green   <= cfg_data[COLOR_W-1:0];
        REG_FILL_BLUE:    fill.blue    <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: capture the pixel
  cell_ctl_t        s1_ctl;
  logic [PX_W-1:0]  s1_px, s1_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else begin
      s1_ctl.valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl.color <= '{red: old_red, green: old_green, blue: old_blue};
    s1_px        <= PX_W'(pixel_x) << FRAC_BITS;
    s1_py        <= PX_W'(pixel_y) << FRAC_BITS;
  end

  // stage 2: coordinate differences per lane (pixel-f1, pixel-f2, f1-f2)
  logic signed [D_W-1:0] pxs, pys, f1xs, f1ys, f2xs, f2ys;
  cell_ctl_t             s2_ctl;
  logic signed [LANES-1:0][D_W-1:0] s2_dx, s2_dy;

  assign pxs  = D_W'(s1_px);
  assign pys  = D_W'(s1_py);
  assign f1xs = D_W'(focus_one_x);
  assign f1ys = D_W'(focus_one_y);
  assign f2xs = D_W'(focus_two_x);
  assign f2ys = D_W'(focus_two_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl.valid <= 1'b0;
    end else begin
      s2_ctl.valid <= s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl.color <= s1_ctl.color;
    s2_dx[0] <= pxs - f1xs;
    s2_dy[0] <= pys - f1ys;
    s2_dx[1] <= pxs - f2xs;
    s2_dy[1] <= pys - f2ys;
    s2_dx[2] <= f1xs - f2xs;
    s2_dy[2] <= f1ys - f2ys;
  end

  // stage 3: squares
  cell_ctl_t                    s3_ctl;
  logic [LANES-1:0][RAD_W-1:0]  s3_sqx, s3_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl.valid <= 1'b0;
    end else begin
      s3_ctl.valid <= s2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_ctl.color <= s2_ctl.color;
    // full-width product: operands widen to RAD_W with their sign
    for (int i = 0; i < LANES; i++) begin
      s3_sqx[i] <= $signed(s2_dx[i]) * $signed(s2_dx[i]);
      s3_sqy[i] <= $signed(s2_dy[i]) * $signed(s2_dy[i]);
    end
  end

  // stage 4: radicands, head of the root chain
  cell_ctl_t                    chain_ctl [ROOT_W+1];
  logic [LANES-1:0][RAD_W-1:0]  chain_rad [ROOT_W+1];
  logic [LANES-1:0][ROOT_W+1:0] chain_rem [ROOT_W+1];
  logic [LANES-1:0][ROOT_W-1:0] chain_root[ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_ctl[0].valid <= 1'b0;
    end else begin
      chain_ctl[0].valid <= s3_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    chain_ctl[0].color <= s3_ctl.color;
    for (int i = 0; i < LANES; i++) begin
      chain_rad[0][i]  <= s3_sqx[i] + s3_sqy[i];
      chain_rem[0][i]  <= '0;
      chain_root[0][i] <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    eps_sqrt_cell #(
      .ROOT_W (ROOT_W),
      .LANES  (LANES)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_ctl   (chain_ctl[k]),
      .in_rad   (chain_rad[k]),
      .in_rem   (chain_rem[k]),
      .in_root  (chain_root[k]),
      .out_ctl  (chain_ctl[k+1]),
      .out_rad  (chain_rad[k+1]),
      .out_rem  (chain_rem[k+1]),
      .out_root (chain_root[k+1])
    );
  end

  // stage 5: add the three distances
  cell_ctl_t        s5_ctl;
  logic [SUM_W-1:0] s5_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_ctl.valid <= 1'b0;
    end else begin
      s5_ctl.valid <= chain_ctl[ROOT_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_ctl.color <= chain_ctl[ROOT_W].color;
    s5_sum <= SUM_W'(chain_root[ROOT_W][0]) + SUM_W'(chain_root[ROOT_W][1])
            + SUM_W'(chain_root[ROOT_W][2]);
  end

  // stage 6: compare and select the color
  logic inside_next;

  assign inside_next = CMP_W'(s5_sum) <= CMP_W'(length_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    inside_res <= inside_next;
    if (inside_next) begin
      new_red   <= fill.red;
      new_green <= fill.green;
      new_blue  <= fill.blue;
    end else begin
      new_red   <= s5_ctl.color.red;
      new_green <= s5_ctl.color.green;
      new_blue  <= s5_ctl.color.blue;
    end
  end

  `EPS_ASSERT_NEXT(a_result_follows_sum, s5_ctl.valid, done)
  `EPS_ASSERT_NEXT(a_no_spurious_result, !s5_ctl.valid, !done)
  `EPS_ASSERT_NEXT(a_limit_write, cfg_valid && cfg_index == REG_LENGTH_LIMIT, length_limit == $past(cfg_data[LIMIT_W-1:0]))

endmodule

[rtl/eps_sqrt_cell.sv]
// One digit step of the square root chain, three lanes side by side
module eps_sqrt_cell import eps_pkg::*; #(
  parameter int ROOT_W = 18,
  parameter int LANES  = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cell_ctl_t                       in_ctl,
  input  logic [LANES-1:0][2*ROOT_W-1:0]  in_rad,
  input  logic [LANES-1:0][ROOT_W+1:0]    in_rem,
  input  logic [LANES-1:0][ROOT_W-1:0]    in_root,
  output cell_ctl_t                       out_ctl,
  output logic [LANES-1:0][2*ROOT_W-1:0]  out_rad,
  output logic [LANES-1:0][ROOT_W+1:0]    out_rem,
  output logic [LANES-1:0][ROOT_W-1:0]    out_root
);

  logic [LANES-1:0][ROOT_W+1:0] rem_next;
  logic [LANES-1:0][ROOT_W-1:0] root_next;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [ROOT_W+1:0] rem_sh;
      logic [ROOT_W+1:0] trial;
      // bring down the next two radicand bits
      rem_sh = {in_rem[i][ROOT_W-1:0], in_rad[i][2*ROOT_W-1 -: 2]};
      trial  = {in_root[i], 2'b01};
      if (rem_sh >= trial) begin
        rem_next[i]  = rem_sh - trial;
        root_next[i] = {in_root[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[i]  = rem_sh;
        root_next[i] = {in_root[i][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ctl.color <= in_ctl.color;
    for (int i = 0; i < LANES; i++) begin
      out_rad[i]  <= in_rad[i] << 2;
      out_rem[i]  <= rem_next[i];
      out_root[i] <= root_next[i];
    end
  end

endmodule

[test/ellipse_pixel_shader_core_tb.sv]
// Testbench for ellipse pixel shader core: directed and random cases against a local predictor
`timescale 1ns / 1ps

module ellipse_pixel_shader_core_tb import eps_pkg::*; ();

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;
  localparam int LATENCY    = 24;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               hit;
  } shade_t;

  class shade_scoreboard;
    logic signed [FOCUS_W-1:0] f1x, f1y, f2x, f2y;
    logic [LIMIT_W-1:0]        limit;
    logic [COLOR_W-1:0]        fill_r, fill_g, fill_b;
    shade_t                    pending[$];
    int                        errors;

    function void clear_regs();
      f1x = '0; f1y = '0; f2x = '0; f2y = '0;
      limit = '0; fill_r = '0; fill_g = '0; fill_b = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FOCUS_ONE_X:  f1x = data[FOCUS_W-1:0];
        REG_FOCUS_ONE_Y:  f1y = data[FOCUS_W-1:0];
        REG_FOCUS_TWO_X:  f2x = data[FOCUS_W-1:0];
        REG_FOCUS_TWO_Y:  f2y = data[FOCUS_W-1:0];
        REG_LENGTH_LIMIT: limit = data[LIMIT_W-1:0];
        REG_FILL_RED:     fill_r = data[COLOR_W-1:0];
        REG_FILL_GREEN:   fill_g = data[COLOR_W-1:0];
        REG_FILL_BLUE:    fill_b = data[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    // Floored square root, one result bit per pass
    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned span(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      dx = ax - bx;
      dy = ay - by;
      return floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
    endfunction

    function void note_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                             logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                             logic [COLOR_W-1:0] b);
      longint px, py, ax, ay, bx, by;
      longint unsigned total;
      shade_t e;
      px = longint'(x) <<< FRAC_BITS;
      py = longint'(y) <<< FRAC_BITS;
      ax = longint'(f1x);
      ay = longint'(f1y);
      bx = longint'(f2x);
      by = longint'(f2y);
      total = span(px, py, ax, ay) + span(px, py, bx, by) + span(ax, ay, bx, by);
      e.hit   = (total <= limit);
      e.red   = e.hit ? fill_r : r;
      e.green = e.hit ? fill_g : g;
      e.blue  = e.hit ? fill_b : b;
      pending.push_back(e);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                      logic [COLOR_W-1:0] b, logic ins);
      shade_t e;
      if (pending.size() == 0) begin
        report("unexpected result, inside", int'(ins), -1);
      end else begin
        e = pending.pop_front();
        if (r !== e.red)   report("new_red", int'(r), int'(e.red));
        if (g !== e.green) report("new_green", int'(g), int'(e.green));
        if (b !== e.blue)  report("new_blue", int'(b), int'(e.blue));
        if (ins !== e.hit) report("inside_res", int'(ins), int'(e.hit));
      end
    endtask
  endclass

  logic clk, rst, start, busy, done, inside_res, cfg_valid, cfg_ready;
  logic [COORD_BITS-1:0] pixel_x, pixel_y;
  logic [COLOR_W-1:0] old_red, old_green, old_blue, new_red, new_green, new_blue;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  shade_scoreboard sb;
  int idle_pct;
  int quiet_cycles;

  ellipse_pixel_shader_core #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) dut (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
        moved = 1'b1;
      end
      if (start && !busy) begin
        sb.note_pixel(pixel_x, pixel_y, old_red, old_green, old_blue);
        moved = 1'b1;
      end
      if (done) begin
        sb.check_result(new_red, new_green, new_blue, inside_res);
        moved = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task send_pixel(int x, int y, logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                  logic [COLOR_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    pixel_x <= COORD_BITS'(x);
    pixel_y <= COORD_BITS'(y);
    old_red <= r;
    old_green <= g;
    old_blue <= b;
    do @(posedge clk); while (busy);
  endtask

  task send_random_pixel();
    send_pixel($urandom_range(4095), $urandom_range(4095),
               COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
               COLOR_W'($urandom_range(255)));
  endtask

  // Drain the pipeline before touching registers
  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(cfg_reg_t idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task set_ellipse(int ax, int ay, int bx, int by, int lim);
    drain();
    write_reg(REG_FOCUS_ONE_X, ax);
    write_reg(REG_FOCUS_ONE_Y, ay);
    write_reg(REG_FOCUS_TWO_X, bx);
    write_reg(REG_FOCUS_TWO_Y, by);
    write_reg(REG_LENGTH_LIMIT, lim);
    write_reg(REG_FILL_RED, $urandom_range(255));
    write_reg(REG_FILL_GREEN, $urandom_range(255));
    write_reg(REG_FILL_BLUE, $urandom_range(255));
  endtask

  initial begin
    int cx, cy;
    sb = new();
    sb.clear_regs();
    sb.errors = 0;
    quiet_cycles = 0;
    idle_pct = 36;
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixel_x = '0;
    pixel_y = '0;
    old_red = '0;
    old_green = '0;
    old_blue = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: only the origin pixel lies inside
    send_pixel(0, 0, 8'hff, 8'h00, 8'haa);
    send_pixel(1, 0, 8'h55, 8'hff, 8'h00);

    // Coincident foci, sum exactly on the limit and one below
    set_ellipse(0, 0, 0, 0, 160);
    send_pixel(3, 4, 8'h12, 8'h34, 8'h56);
    set_ellipse(0, 0, 0, 0, 159);
    send_pixel(3, 4, 8'h12, 8'h34, 8'h56);
    set_ellipse(160, 160, 160, 160, 0);
    send_pixel(10, 10, 8'h00, 8'hff, 8'h0f);
    send_pixel(10, 11, 8'hf0, 8'h00, 8'hff);

    // Extreme foci and the widest limit
    set_ellipse(-32768, -32768, 32767, 32767, 524287);
    send_pixel(0, 0, 8'hff, 8'hff, 8'hff);
    send_pixel(4095, 4095, 8'h00, 8'h00, 8'h00);
    send_pixel(4095, 0, 8'haa, 8'h55, 8'h01);
    send_pixel(0, 4095, 8'h55, 8'haa, 8'h80);
    set_ellipse(32767, -32768, -32768, 32767, 0);
    send_pixel(4095, 4095, 8'hff, 8'h00, 8'hff);
    send_pixel(2048, 2048, 8'h01, 8'h02, 8'h04);
    set_ellipse(-32768, 32767, -32768, 32767, 524287);
    send_pixel(0, 4095, 8'h7f, 8'h80, 8'hfe);
    send_pixel(4095, 0, 8'h80, 8'h7f, 8'h01);

    for (int phase = 0; phase < 9; phase++) begin
      cx = $urandom_range(65535);
      cy = $urandom_range(65535);
      if (phase == 8)
        set_ellipse(cx, cy, $urandom_range(65535), $urandom_range(65535), 524287);
      else
        set_ellipse(cx, cy, cx + $urandom_range(8000) - 4000, cy + $urandom_range(8000) - 4000,
                    $urandom_range(60000));
      idle_pct = (phase == 3) ? 0 : 36;
      for (int n = 0; n < 145; n++) begin
        if (phase < 8 && $urandom_range(3) != 0)
          // Mostly pixels near the ellipse so both outcomes show up
          send_pixel((((cx >>> 4) + $urandom_range(600) - 300) & 12'hfff),
                     (((cy >>> 4) + $urandom_range(600) - 300) & 12'hfff),
                     COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
                     COLOR_W'($urandom_range(255)));
        else
          send_random_pixel();
      end
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
